// ===== rtl/rtgm_pkg.sv =====
package rtgm_pkg;

    localparam logic [2:0] CMD_RANGE = 3'd0;
    localparam logic [2:0] CMD_FWD   = 3'd1;
    localparam logic [2:0] CMD_BACK  = 3'd2;
    localparam logic [2:0] CMD_ROTM  = 3'd3;
    localparam logic [2:0] CMD_ROTP  = 3'd4;
    localparam logic [2:0] CMD_QUERY = 3'd5;

    localparam logic [1:0] SNS_FRONT = 2'd0;
    localparam logic [1:0] SNS_RIGHT = 2'd1;
    localparam logic [1:0] SNS_LEFT  = 2'd2;
    localparam logic [1:0] SNS_NONE  = 2'd3;

    localparam logic [1:0] CFG_STEP = 2'd0;
    localparam logic [1:0] CFG_MAXR = 2'd1;

    // floor(d * 343 / 20000) as (d * DIST_MUL) >> DIST_SHIFT, exact for 20 bit d
    localparam int          DIST_SHIFT = 35;
    localparam logic [63:0] DIST_NUM   = 64'd343 << DIST_SHIFT;
    localparam logic [29:0] DIST_MUL   = 30'((DIST_NUM + 64'd19999) / 64'd20000);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MARK,
        OP_FWD,
        OP_BACK,
        OP_ROTM,
        OP_ROTP,
        OP_QUERY
    } t_op;

    typedef struct packed {
        logic [2:0]  command;
        logic [19:0] echo_duration;
        logic [1:0]  sensor;
        logic [6:0]  query_x;
        logic [7:0]  query_y;
    } t_in;

    typedef struct packed {
        logic signed [15:0] pose_x;
        logic signed [15:0] pose_y;
        logic [1:0]         heading_quarter;
        logic               cell_marked;
        logic [6:0]         mark_x;
        logic [7:0]         mark_y;
        logic               cell_value;
    } t_res;

    typedef struct packed {
        t_op        op;
        logic [1:0] sensor;
        logic [9:0] reach;
        logic [6:0] qx;
        logic [7:0] qy;
    } t_cmd;

endpackage

// ===== rtl/rtgm_front.sv =====
module rtgm_front import rtgm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in,
    input  logic       i_hold,
    input  logic [9:0] i_max_range,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_full
);

    logic        r_s1_valid;
    t_in         r_s1;
    logic        r_s2_valid;
    logic [2:0]  r_s2_command;
    logic [1:0]  r_s2_sensor;
    logic [6:0]  r_s2_qx;
    logic [7:0]  r_s2_qy;
    logic [14:0] r_s2_dist;

    logic        w_adv;
    logic        w_acc;
    logic [49:0] w_prod;

    assign w_adv      = !r_s2_valid || !i_full;
    assign o_in_stall = i_hold || !w_adv;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_prod     = 50'(r_s1.echo_duration) * 50'(DIST_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_acc;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1         <= i_in;
            r_s2_command <= r_s1.command;
            r_s2_sensor  <= r_s1.sensor;
            r_s2_qx      <= r_s1.query_x;
            r_s2_qy      <= r_s1.query_y;
            r_s2_dist    <= w_prod[DIST_SHIFT +: 15];
        end
    end

    assign o_push = r_s2_valid && !i_full;

    always_comb begin
        o_cmd.sensor = r_s2_sensor;
        o_cmd.reach  = r_s2_dist[9:0];
        o_cmd.qx     = r_s2_qx;
        o_cmd.qy     = r_s2_qy;
        unique case (r_s2_command)
            CMD_RANGE: begin
                if (r_s2_dist <= 15'(i_max_range) && r_s2_sensor != SNS_NONE) begin
                    o_cmd.op = OP_MARK;
                end else begin
                    o_cmd.op = OP_NONE;
                end
            end
            CMD_FWD:   o_cmd.op = OP_FWD;
            CMD_BACK:  o_cmd.op = OP_BACK;
            CMD_ROTM:  o_cmd.op = OP_ROTM;
            CMD_ROTP:  o_cmd.op = OP_ROTP;
            CMD_QUERY: o_cmd.op = OP_QUERY;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/rtgm_queue.sv =====
module rtgm_queue import rtgm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd            r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = r_cnt == (Q_AW + 1)'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW + 1)'(i_push) - (Q_AW + 1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_cnt == (Q_AW + 1)'($past(r_cnt) + (Q_AW + 1)'($past(i_push))
                                       - (Q_AW + 1)'($past(i_pop))))
        else $error("queue count out of step");

endmodule

// ===== rtl/rtgm_back.sv =====
module rtgm_back import rtgm_pkg::*; #(
    parameter int GRID_WIDTH  = 100,
    parameter int GRID_HEIGHT = 150
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_step,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       o_busy,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_res       o_out
);

    localparam int CXW   = $clog2(GRID_WIDTH);
    localparam int CYW   = $clog2(GRID_HEIGHT);
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);

    logic signed [15:0] r_rx;
    logic signed [15:0] r_ry;
    logic [1:0]         r_hd;
    logic               r_busy;
    logic [AW-1:0]      r_clr;
    logic               r_mem [CELLS];
    logic               r_rdata;
    logic               r_qok;
    logic               r_out_valid;
    t_res               r_res;

    logic signed [15:0] n_rx;
    logic signed [15:0] n_ry;
    logic [1:0]         n_hd;
    t_res               n_res;

    logic [1:0]         w_dir;
    logic [17:0]        w_amt;
    logic signed [17:0] w_base;
    logic signed [17:0] w_sum;
    logic signed [17:0] w_tx;
    logic signed [17:0] w_ty;
    logic               w_tok;
    logic               w_qok;
    logic               w_is_mark;
    logic [CXW-1:0]     w_xs;
    logic [CYW-1:0]     w_ys;
    logic [AW-1:0]      w_idx;
    logic [AW-1:0]      w_addr;
    logic               w_we;
    logic               w_re;
    logic signed [15:0] w_sat;

    function automatic logic signed [15:0] f_sat(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'sh7fff;
        end else if (v < -18'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    assign o_pop     = !i_empty && !r_busy && (!r_out_valid || !i_out_stall);
    assign o_busy    = r_busy;
    assign w_is_mark = i_head.op == OP_MARK;

    // heading 0 is +y, 1 is +x, 2 is -y, 3 is -x
    always_comb begin
        w_dir = r_hd;
        w_amt = 18'(i_step);
        case (i_head.op)
            OP_MARK: begin
                w_amt = 18'(i_head.reach);
                case (i_head.sensor)
                    SNS_RIGHT: w_dir = r_hd + 2'd1;
                    SNS_LEFT:  w_dir = r_hd + 2'd3;
                    default:   w_dir = r_hd;
                endcase
            end
            OP_BACK: w_dir = r_hd + 2'd2;
            default: w_dir = r_hd;
        endcase
        w_base = w_dir[0] ? 18'(r_rx) : 18'(r_ry);
        w_sum  = w_dir[1] ? w_base - $signed(w_amt) : w_base + $signed(w_amt);
        w_tx   = w_dir[0] ? w_sum : 18'(r_rx);
        w_ty   = w_dir[0] ? 18'(r_ry) : w_sum;
        w_sat  = f_sat(w_sum);
        w_tok  = !w_tx[17] && (w_tx[16:0] < 17'(GRID_WIDTH))
              && !w_ty[17] && (w_ty[16:0] < 17'(GRID_HEIGHT));
        w_qok  = (11'(i_head.qx) < 11'(GRID_WIDTH)) && (11'(i_head.qy) < 11'(GRID_HEIGHT));
        w_xs   = w_is_mark ? w_tx[CXW-1:0] : CXW'(i_head.qx);
        w_ys   = w_is_mark ? w_ty[CYW-1:0] : CYW'(i_head.qy);
        w_idx  = AW'(w_xs) + AW'(GRID_WIDTH) * AW'(w_ys);
    end

    always_comb begin
        n_rx = r_rx;
        n_ry = r_ry;
        n_hd = r_hd;
        case (i_head.op)
            OP_FWD, OP_BACK: begin
                if (w_dir[0]) begin
                    n_rx = w_sat;
                end else begin
                    n_ry = w_sat;
                end
            end
            OP_ROTM: n_hd = r_hd - 2'd1;
            OP_ROTP: n_hd = r_hd + 2'd1;
            default: n_hd = r_hd;
        endcase
        n_res.pose_x          = n_rx;
        n_res.pose_y          = n_ry;
        n_res.heading_quarter = n_hd;
        n_res.cell_marked     = w_is_mark && w_tok;
        n_res.mark_x          = (w_is_mark && w_tok) ? w_tx[6:0] : 7'd0;
        n_res.mark_y          = (w_is_mark && w_tok) ? w_ty[7:0] : 8'd0;
        n_res.cell_value      = 1'b0;
    end

    assign w_addr = r_busy ? r_clr : w_idx;
    assign w_we   = r_busy || (o_pop && w_is_mark && w_tok);
    assign w_re   = o_pop && i_head.op == OP_QUERY;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= !r_busy;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx        <= '0;
            r_ry        <= '0;
            r_hd        <= '0;
            r_busy      <= 1'b1;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_busy) begin
                if (r_clr == AW'(CELLS - 1)) begin
                    r_busy <= 1'b0;
                end
                r_clr <= r_clr + 1'b1;
            end
            if (o_pop) begin
                r_rx        <= n_rx;
                r_ry        <= n_ry;
                r_hd        <= n_hd;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
            r_qok <= (i_head.op == OP_QUERY) && w_qok;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out            = r_res;
        o_out.cell_value = r_rdata && r_qok;
    end

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_pop && !r_out_valid)
        else $error("word issued during grid clear");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(o_out))
        else $error("stalled result word changed");

endmodule

// ===== rtl/range_to_occupancy_grid_mapper.sv =====
// Occupancy grid mapper: keeps a robot pose and a one bit per cell grid, marks the cell hit
// by each range reading and answers cell queries, one result word per input word. After
// reset the grid is cleared one cell per cycle, with the input stalled meanwhile;
// configuration writes are taken at any time. Sustained rate is one word per cycle while
// the result side does not stall: the front end registers the word and converts the echo
// with one multiply into its second stage, and the back end does the pose update and its
// single grid access (one write or one registered read on one memory port) for each word.
// With no stalls a word passes the front-end registers, the queue and the result register.
module range_to_occupancy_grid_mapper import rtgm_pkg::*; #(
    parameter int GRID_WIDTH  = 100,
    parameter int GRID_HEIGHT = 150
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_res       o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_data
);

    logic [7:0] r_step;
    logic [9:0] r_maxr;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    logic w_busy;
    t_cmd w_cmd;
    t_cmd w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 8'd5;
            r_maxr <= 10'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP: r_step <= i_cfg_data[7:0];
                CFG_MAXR: r_maxr <= i_cfg_data;
                default:  r_step <= r_step;
            endcase
        end
    end

    rtgm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_hold      (w_busy),
        .i_max_range (r_maxr),
        .o_push      (w_push),
        .o_cmd       (w_cmd),
        .i_full      (w_full)
    );

    rtgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    rtgm_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (r_step),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ===== tb/rtgm_checker.sv =====
module rtgm_checker import rtgm_pkg::*; #(
    parameter int GRID_WIDTH  = 100,
    parameter int GRID_HEIGHT = 150
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in        i_in,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_res       i_out,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_data,
    output int         o_pending,
    output int         o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    bit         occ_grid [GRID_WIDTH * GRID_HEIGHT];
    int         rob_x;
    int         rob_y;
    logic [1:0] rob_hdg;
    int         step_cells;
    int         max_dist;
    t_res       pending_results [$];
    int         n_results;

    task automatic report_mismatch(input string what);
        $display("[%0t] rtgm: result %0d: %s", $time, n_results, what);
        o_fail_count++;
    endtask

    function automatic int clamp16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic t_res advance_mapper(input t_in w);
        t_res r;
        int   sn;
        int   cs;
        int   span;
        int   tx;
        int   ty;
        int   mv;
        r  = '0;
        sn = (rob_hdg == 2'd1) ? 1 : (rob_hdg == 2'd3) ? -1 : 0;
        cs = (rob_hdg == 2'd0) ? 1 : (rob_hdg == 2'd2) ? -1 : 0;
        case (w.command)
            CMD_RANGE: begin
                span = int'(w.echo_duration) * 343 / 20000;
                if (span <= max_dist && w.sensor <= SNS_LEFT) begin
                    case (w.sensor)
                        SNS_FRONT: begin
                            tx = rob_x + span * sn;
                            ty = rob_y + span * cs;
                        end
                        SNS_RIGHT: begin
                            tx = rob_x + span * cs;
                            ty = rob_y - span * sn;
                        end
                        default: begin
                            tx = rob_x - span * cs;
                            ty = rob_y + span * sn;
                        end
                    endcase
                    if (tx >= 0 && tx < GRID_WIDTH && ty >= 0 && ty < GRID_HEIGHT) begin
                        occ_grid[tx + GRID_WIDTH * ty] = 1'b1;
                        r.cell_marked = 1'b1;
                        r.mark_x      = 7'(tx);
                        r.mark_y      = 8'(ty);
                    end
                end
            end
            CMD_FWD, CMD_BACK: begin
                mv    = (w.command == CMD_BACK) ? -step_cells : step_cells;
                rob_x = clamp16(rob_x + mv * sn);
                rob_y = clamp16(rob_y + mv * cs);
            end
            CMD_ROTM: rob_hdg = rob_hdg - 2'd1;
            CMD_ROTP: rob_hdg = rob_hdg + 2'd1;
            CMD_QUERY: begin
                if (int'(w.query_x) < GRID_WIDTH && int'(w.query_y) < GRID_HEIGHT) begin
                    r.cell_value = occ_grid[int'(w.query_x) + GRID_WIDTH * int'(w.query_y)];
                end
            end
            default: ;
        endcase
        r.pose_x          = 16'(rob_x);
        r.pose_y          = 16'(rob_y);
        r.heading_quarter = rob_hdg;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            foreach (occ_grid[k]) occ_grid[k] = 1'b0;
            rob_x      = 0;
            rob_y      = 0;
            rob_hdg    = '0;
            step_cells = 5;
            max_dist   = 100;
            n_results  = 0;
            pending_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STEP: step_cells = int'(i_cfg_data[7:0]);
                    CFG_MAXR: max_dist   = int'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    report_mismatch("word arrived with nothing outstanding");
                end else begin
                    want = pending_results.pop_front();
                    if (i_out.pose_x !== want.pose_x)
                        report_mismatch($sformatf("pose_x got %0d want %0d",
                                                  i_out.pose_x, want.pose_x));
                    if (i_out.pose_y !== want.pose_y)
                        report_mismatch($sformatf("pose_y got %0d want %0d",
                                                  i_out.pose_y, want.pose_y));
                    if (i_out.heading_quarter !== want.heading_quarter)
                        report_mismatch($sformatf("heading_quarter got %0d want %0d",
                                                  i_out.heading_quarter, want.heading_quarter));
                    if (i_out.cell_marked !== want.cell_marked)
                        report_mismatch($sformatf("cell_marked got %0d want %0d",
                                                  i_out.cell_marked, want.cell_marked));
                    if (i_out.mark_x !== want.mark_x)
                        report_mismatch($sformatf("mark_x got %0d want %0d",
                                                  i_out.mark_x, want.mark_x));
                    if (i_out.mark_y !== want.mark_y)
                        report_mismatch($sformatf("mark_y got %0d want %0d",
                                                  i_out.mark_y, want.mark_y));
                    if (i_out.cell_value !== want.cell_value)
                        report_mismatch($sformatf("cell_value got %0d want %0d",
                                                  i_out.cell_value, want.cell_value));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(advance_mapper(i_in));
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

// ===== tb/tb_range_to_occupancy_grid_mapper.sv =====
module tb_range_to_occupancy_grid_mapper;
    timeunit 1ns;
    timeprecision 1ps;
    import rtgm_pkg::*;

    localparam int         GRID_W  = 100;
    localparam int         GRID_H  = 150;
    localparam int         GRID_CX = GRID_W / 2;
    localparam int         GRID_CY = GRID_H / 2;
    localparam int         IN_W    = $bits(t_in);
    localparam logic [2:0] CMD_NOP6 = 3'd6;
    localparam logic [2:0] CMD_NOP7 = 3'd7;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in        i_in;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_res       o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [9:0] i_cfg_data;

    int          pending;
    int          fails;
    int          cur_step;
    int          cur_max;
    bit          in_quiet;
    bit          out_quiet;
    int          stall_run;
    int          last_x;
    int          last_y;
    bit [1:0]    last_h;
    logic [14:0] seen_cells [$];

    always #6 i_clk = ~i_clk;

    range_to_occupancy_grid_mapper #(
        .GRID_WIDTH (GRID_W),
        .GRID_HEIGHT(GRID_H)
    ) u_dut (.*);

    rtgm_checker #(
        .GRID_WIDTH (GRID_W),
        .GRID_HEIGHT(GRID_H)
    ) u_check (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .i_in_stall  (o_in_stall),
        .i_in,
        .i_out_valid (o_out_valid),
        .i_out_stall,
        .i_out       (o_out),
        .i_cfg_valid,
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index,
        .i_cfg_data,
        .o_pending   (pending),
        .o_fail_count(fails)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result-side backpressure
    always @(posedge i_clk) begin
        if (stall_run > 0) begin
            i_out_stall <= 1'b1;
            stall_run   <= stall_run - 1;
        end else if (!out_quiet && $urandom_range(0, 99) < 30) begin
            i_out_stall <= 1'b1;
            stall_run   <= idle_len() - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
        if ($urandom_range(0, 199) == 0) out_quiet <= ~out_quiet;
    end

    // latest pose and marked cells seen on the result side, used to steer stimulus
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            last_x <= int'(o_out.pose_x);
            last_y <= int'(o_out.pose_y);
            last_h <= o_out.heading_quarter;
            if (o_out.cell_marked) begin
                seen_cells.push_back({o_out.mark_y, o_out.mark_x});
                if (seen_cells.size() > 64) void'(seen_cells.pop_front());
            end
        end
    end

    function automatic logic [19:0] echo_for(input int span);
        int lo;
        int hi;
        lo = (span * 20000 + 342) / 343;
        hi = ((span + 1) * 20000 + 342) / 343 - 1;
        if (hi > 20'hFFFFF) hi = 20'hFFFFF;
        return 20'($urandom_range(hi, lo));
    endfunction

    function automatic t_in word(input logic [2:0] cmd, input logic [19:0] dur,
                                 input logic [1:0] sns, input logic [6:0] qx,
                                 input logic [7:0] qy);
        t_in w;
        w.command       = cmd;
        w.echo_duration = dur;
        w.sensor        = sns;
        w.query_x       = qx;
        w.query_y       = qy;
        return w;
    endfunction

    function automatic t_in junk_word();
        return t_in'(IN_W'({$urandom, $urandom}));
    endfunction

    function automatic logic [2:0] steer_cmd(input int tol);
        int err;
        err = last_h[0] ? GRID_CX - last_x : GRID_CY - last_y;
        if (last_h[1]) err = -err;
        if (err > tol) return CMD_FWD;
        if (err < -tol) return CMD_BACK;
        return CMD_ROTP;
    endfunction

    function automatic t_in rand_word();
        t_in w;
        int  r;
        w = junk_word();
        r = $urandom_range(0, 99);
        if (r < 45) begin
            w.command = CMD_RANGE;
            w.sensor  = ($urandom_range(0, 9) == 0) ? SNS_NONE : 2'($urandom_range(0, 2));
            r = $urandom_range(0, 19);
            if (r < 2) begin
                w.echo_duration = 20'($urandom);
            end else if (r == 2) begin
                w.echo_duration = echo_for(cur_max + $urandom_range(0, 1));
            end else begin
                w.echo_duration = echo_for($urandom_range(0, cur_max + 20));
            end
        end else if (r < 65) begin
            w.command = CMD_QUERY;
            r = $urandom_range(0, 19);
            if (r < 10 && seen_cells.size() > 0) begin
                {w.query_y, w.query_x} = seen_cells[$urandom_range(0, seen_cells.size() - 1)];
            end else if (r < 17) begin
                w.query_x = 7'($urandom_range(0, GRID_W - 1));
                w.query_y = 8'($urandom_range(0, GRID_H - 1));
            end
        end else if (r < 85) begin
            if ($urandom_range(0, 9) < 7) begin
                w.command = steer_cmd(cur_step);
            end else begin
                w.command = $urandom_range(0, 1) ? CMD_FWD : CMD_BACK;
            end
        end else if (r < 95) begin
            w.command = $urandom_range(0, 1) ? CMD_ROTM : CMD_ROTP;
        end else if (r < 98) begin
            w.command = $urandom_range(0, 1) ? CMD_NOP6 : CMD_NOP7;
        end
        return w;
    endfunction

    task automatic send_word(input t_in w);
        int gap;
        if ($urandom_range(0, 63) == 0) in_quiet = ~in_quiet;
        gap = (in_quiet || $urandom_range(0, 1)) ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [9:0] step_val, input logic [9:0] range_val);
        drain();
        repeat (8) @(posedge i_clk);
        write_reg(CFG_STEP, step_val);
        write_reg(CFG_MAXR, range_val);
        cur_step = int'(step_val[7:0]);
        cur_max  = int'(range_val);
    endtask

    task automatic face(input logic [1:0] h);
        t_in        w;
        logic [1:0] turns;
        drain();
        turns = h - last_h;
        repeat (turns) begin
            w = junk_word();
            w.command = CMD_ROTP;
            send_word(w);
        end
    endtask

    task automatic run_forward(input int count);
        t_in w;
        repeat (count) begin
            w = junk_word();
            w.command = ($urandom_range(0, 9) == 0) ? CMD_RANGE : CMD_FWD;
            send_word(w);
        end
    endtask

    // closed loop: one word at a time so the steering sees the current pose
    task automatic home(input int tol);
        t_in w;
        int  n;
        drain();
        n = 0;
        while (n < 400 && (last_x - GRID_CX > tol || GRID_CX - last_x > tol ||
                           last_y - GRID_CY > tol || GRID_CY - last_y > tol)) begin
            w = junk_word();
            w.command = steer_cmd(tol);
            send_word(w);
            drain();
            n++;
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        cur_step = 5;
        cur_max  = 100;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(word(CMD_RANGE, 20'd0, SNS_FRONT, 7'd0, 8'd0));
        send_word(word(CMD_QUERY, 20'd0, SNS_FRONT, 7'd0, 8'd0));
        send_word(word(CMD_QUERY, 20'hFFFFF, SNS_NONE, 7'd127, 8'd255));
        send_word(word(CMD_QUERY, 20'd0, SNS_FRONT, 7'd99, 8'd149));
        send_word(word(CMD_QUERY, 20'd0, SNS_FRONT, 7'd100, 8'd0));
        send_word(word(CMD_QUERY, 20'd0, SNS_FRONT, 7'd0, 8'd150));
        send_word(word(CMD_RANGE, 20'hFFFFF, SNS_FRONT, 7'd0, 8'd0));
        send_word(word(CMD_RANGE, echo_for(5), SNS_NONE, 7'd0, 8'd0));
        send_word(word(CMD_FWD, 20'd0, SNS_FRONT, 7'd0, 8'd0));
        send_word(word(CMD_RANGE, echo_for(10), SNS_RIGHT, 7'd0, 8'd0));
        send_word(word(CMD_RANGE, echo_for(10), SNS_LEFT, 7'd0, 8'd0));
        send_word(word(CMD_ROTP, 20'd0, SNS_FRONT, 7'd0, 8'd0));
        send_word(word(CMD_FWD, 20'd0, SNS_FRONT, 7'd0, 8'd0));
        send_word(word(CMD_RANGE, echo_for(100), SNS_LEFT, 7'd0, 8'd0));
        send_word(word(CMD_RANGE, echo_for(101), SNS_LEFT, 7'd0, 8'd0));
        send_word(word(CMD_QUERY, 20'd0, SNS_FRONT, 7'd5, 8'd105));
        send_word(word(CMD_QUERY, 20'd0, SNS_FRONT, 7'd5, 8'd106));
        send_word(word(CMD_QUERY, 20'd0, SNS_FRONT, 7'd10, 8'd5));
        send_word(word(CMD_ROTM, 20'd0, SNS_FRONT, 7'd0, 8'd0));
        send_word(word(CMD_ROTM, 20'd0, SNS_FRONT, 7'd0, 8'd0));
        send_word(word(CMD_BACK, 20'd0, SNS_FRONT, 7'd0, 8'd0));
        send_word(word(CMD_RANGE, echo_for(3), SNS_FRONT, 7'd0, 8'd0));
        send_word(word(CMD_NOP6, 20'hFFFFF, SNS_LEFT, 7'd5, 8'd105));
        send_word(word(CMD_NOP7, 20'd12345, SNS_RIGHT, 7'd7, 8'd5));
        send_word(word(CMD_QUERY, 20'd0, SNS_FRONT, 7'd7, 8'd5));

        configure(10'd0, 10'd0);
        write_reg(CFG_SPARE_A, 10'($urandom));
        write_reg(CFG_SPARE_B, 10'($urandom));
        repeat (150) send_word(rand_word());

        configure(10'($urandom_range(1, 9)), 10'($urandom_range(60, 200)));
        repeat (400) send_word(rand_word());

        // step field masked to 8 bits: 255 cells per move
        configure(10'h3FF, 10'h3FF);
        face(2'd1);
        run_forward(135);
        face(2'd2);
        run_forward(135);
        home(cur_step);

        configure(10'd8, 10'd1023);
        home(cur_step);
        repeat (300) send_word(rand_word());

        configure(10'd1, 10'($urandom_range(120, 160)));
        repeat (200) send_word(rand_word());

        drain();
        repeat (10) @(posedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("range_to_occupancy_grid_mapper: match");
        end else begin
            $display("range_to_occupancy_grid_mapper: mismatch");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("range_to_occupancy_grid_mapper: mismatch");
        $finish;
    end

endmodule
